### sv/four_key_debounce_long_press_chord_assert.svh
// Assertion helpers shared by the key poller modules.
`ifndef FOUR_KEY_DEBOUNCE_LONG_PRESS_CHORD_ASSERT_SVH
`define FOUR_KEY_DEBOUNCE_LONG_PRESS_CHORD_ASSERT_SVH

// Condition holds at every edge outside reset.
`define FKDC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent at the same edge.
`define FKDC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent at the next edge.
`define FKDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fkdc_pkg.sv
// ----------------------------------------------------------------------------
// fkdc_pkg
// Types and constants of the four-key poller: event codes, key indexes,
// register indexes and the per-poll result record.
// ----------------------------------------------------------------------------
package fkdc_pkg;

    localparam int TIME_W     = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_KEYS   = 4;
    localparam int NUM_TIMERS = 5;
    localparam int MAX_EVENTS = 4;
    localparam int EVIDX_W    = $clog2(MAX_EVENTS);
    localparam int EVCNT_W    = $clog2(MAX_EVENTS + 1);

    // Key and timer slots
    localparam int KEY_LEFT  = 0;
    localparam int KEY_RIGHT = 1;
    localparam int KEY_OK    = 2;
    localparam int KEY_BACK  = 3;
    localparam int KEY_CHORD = 4;

    // Event slots before packing
    localparam int SLOT_SIDE0 = 0;
    localparam int SLOT_SIDE1 = 1;
    localparam int SLOT_OK    = 2;
    localparam int SLOT_BACK  = 3;

    typedef enum logic [3:0] {
        EV_LEFT       = 4'd0,
        EV_RIGHT      = 4'd1,
        EV_OK         = 4'd2,
        EV_BACK       = 4'd3,
        EV_LEFT_LONG  = 4'd4,
        EV_RIGHT_LONG = 4'd5,
        EV_UP         = 4'd6,
        EV_DOWN       = 4'd7,
        EV_EXIT       = 4'd8
    } event_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_EXIT_HOLD  = 2'd2
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd500;
    localparam logic [CFG_W-1:0] EXIT_HOLD_RESET  = 16'd5000;

    // Short and long codes of left and right
    localparam event_code_t SHORT_CODE [2] = '{EV_LEFT, EV_RIGHT};
    localparam event_code_t LONG_CODE  [2] = '{EV_LEFT_LONG, EV_RIGHT_LONG};

    // Everything one poll produces, events packed from index 0
    typedef struct packed {
        logic                            has_event;
        logic [EVIDX_W-1:0]              last_idx;
        event_code_t [MAX_EVENTS-1:0]    codes;
    } poll_result_t;

endpackage

### sv/fkdc_ifs.sv
// ----------------------------------------------------------------------------
// fkdc_ifs
// Valid/ready channels of the key poller: poll input, event output and
// register write port.
// ----------------------------------------------------------------------------
interface fkdc_poll_if;
    logic                        valid;
    logic                        ready;
    logic [fkdc_pkg::TIME_W-1:0] now_ms;
    logic                        left_level;
    logic                        right_level;
    logic                        ok_level;
    logic                        back_level;

    modport source (
        output valid, now_ms, left_level, right_level, ok_level, back_level,
        input  ready
    );
    modport sink (
        input  valid, now_ms, left_level, right_level, ok_level, back_level,
        output ready
    );
endinterface

interface fkdc_event_if;
    logic       valid;
    logic       ready;
    logic       has_event;
    logic [3:0] event_code;
    logic       last_of_poll;

    modport source (
        output valid, has_event, event_code, last_of_poll,
        input  ready
    );
    modport sink (
        input  valid, has_event, event_code, last_of_poll,
        output ready
    );
endinterface

interface fkdc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fkdc_pkg::CFG_IDX_W-1:0] index;
    logic [fkdc_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/fkdc_front.sv
// ----------------------------------------------------------------------------
// fkdc_front
// Poll front end: holds the key state and timing registers, debounces the
// four keys, resolves chord, long press and exit, and packs the events of
// one poll into a single record for the queue.
// ----------------------------------------------------------------------------
module fkdc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    fkdc_poll_if.sink              poll,
    fkdc_cfg_if.sink               cfg,
    input  logic                   q_full,
    output logic                   q_push,
    output fkdc_pkg::poll_result_t q_data
);
    import fkdc_pkg::*;

    logic [CFG_W-1:0]      debounce_reg;
    logic [CFG_W-1:0]      long_press_reg;
    logic [CFG_W-1:0]      exit_hold_reg;

    logic [NUM_TIMERS-1:0] pressed_reg, pressed_next;
    logic [1:0]            side_long_reg, side_long_next;
    logic                  back_long_reg, back_long_next;
    logic                  chord_reg, chord_next;
    logic [TIME_W-1:0]     change_reg  [NUM_TIMERS];
    logic [TIME_W-1:0]     change_next [NUM_TIMERS];

    logic [TIME_W-1:0]     since      [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] settled;
    logic [1:0]            long_hit;
    logic                  exit_hit;
    logic [NUM_KEYS-1:0]   lvl;

    logic [MAX_EVENTS-1:0] slot_v;
    event_code_t           slot_c [MAX_EVENTS];
    event_code_t [MAX_EVENTS-1:0] packed_codes;
    logic [EVCNT_W-1:0]    ev_cnt;

    logic                  accept;

    assign poll.ready = !q_full;
    assign accept     = poll.valid && poll.ready;
    assign q_push     = accept;
    assign cfg.ready  = 1'b1;

    assign lvl = {poll.back_level, poll.ok_level, poll.right_level, poll.left_level};

    // Elapsed time per key and threshold compares
    always_comb
    begin
        for (int k = 0; k < NUM_TIMERS; k++)
        begin
            since[k]   = poll.now_ms - change_reg[k];
            settled[k] = since[k] > {{(TIME_W-CFG_W){1'b0}}, debounce_reg};
        end
        for (int k = 0; k < 2; k++)
        begin
            long_hit[k] = since[k] > {{(TIME_W-CFG_W){1'b0}}, long_press_reg};
        end
        exit_hit = since[KEY_BACK] > {{(TIME_W-CFG_W){1'b0}}, exit_hold_reg};
    end

    // Key state transitions and event slots
    always_comb
    begin
        pressed_next   = pressed_reg;
        side_long_next = side_long_reg;
        back_long_next = back_long_reg;
        chord_next     = chord_reg;
        change_next    = change_reg;
        slot_v         = '0;
        for (int i = 0; i < MAX_EVENTS; i++)
        begin
            slot_c[i] = EV_LEFT;
        end

        // Enter or leave chord mode
        if (lvl[KEY_LEFT] && lvl[KEY_RIGHT])
        begin
            chord_next             = 1'b0;
            pressed_next[KEY_CHORD] = 1'b0;
        end
        else if (!lvl[KEY_LEFT] && !lvl[KEY_RIGHT])
        begin
            chord_next              = 1'b1;
            pressed_next[KEY_LEFT]  = 1'b0;
            pressed_next[KEY_RIGHT] = 1'b0;
        end

        if (chord_next)
        begin
            // Chord: release of one key gives up or down
            if (!lvl[KEY_LEFT] && !lvl[KEY_RIGHT] && !pressed_reg[KEY_CHORD]
                && settled[KEY_CHORD])
            begin
                pressed_next[KEY_CHORD] = 1'b1;
                change_next[KEY_CHORD]  = poll.now_ms;
            end
            else if (lvl[KEY_LEFT] && !lvl[KEY_RIGHT] && pressed_reg[KEY_CHORD]
                     && settled[KEY_CHORD])
            begin
                pressed_next[KEY_CHORD] = 1'b0;
                change_next[KEY_CHORD]  = poll.now_ms;
                slot_v[SLOT_SIDE0]      = 1'b1;
                slot_c[SLOT_SIDE0]      = EV_UP;
            end
            else if (!lvl[KEY_LEFT] && lvl[KEY_RIGHT] && pressed_reg[KEY_CHORD]
                     && settled[KEY_CHORD])
            begin
                pressed_next[KEY_CHORD] = 1'b0;
                change_next[KEY_CHORD]  = poll.now_ms;
                slot_v[SLOT_SIDE0]      = 1'b1;
                slot_c[SLOT_SIDE0]      = EV_DOWN;
            end
        end
        else
        begin
            // Left and right: short on release, repeating long while held
            for (int k = 0; k < 2; k++)
            begin
                if (!lvl[k] && !pressed_reg[k] && settled[k])
                begin
                    pressed_next[k]   = 1'b1;
                    side_long_next[k] = 1'b0;
                    change_next[k]    = poll.now_ms;
                end
                else if (!lvl[k] && long_hit[k])
                begin
                    side_long_next[k] = 1'b1;
                    change_next[k]    = poll.now_ms;
                    slot_v[k]         = 1'b1;
                    slot_c[k]         = LONG_CODE[k];
                end
                else if (lvl[k] && pressed_reg[k] && settled[k])
                begin
                    pressed_next[k] = 1'b0;
                    change_next[k]  = poll.now_ms;
                    slot_v[k]       = !side_long_reg[k];
                    slot_c[k]       = SHORT_CODE[k];
                end
            end
        end

        // Ok: event on release
        if (!lvl[KEY_OK] && !pressed_reg[KEY_OK] && settled[KEY_OK])
        begin
            pressed_next[KEY_OK] = 1'b1;
            change_next[KEY_OK]  = poll.now_ms;
        end
        else if (lvl[KEY_OK] && pressed_reg[KEY_OK] && settled[KEY_OK])
        begin
            pressed_next[KEY_OK] = 1'b0;
            change_next[KEY_OK]  = poll.now_ms;
            slot_v[SLOT_OK]      = 1'b1;
            slot_c[SLOT_OK]      = EV_OK;
        end

        // Back: short on release, exit once per hold
        if (!lvl[KEY_BACK] && !pressed_reg[KEY_BACK] && settled[KEY_BACK])
        begin
            pressed_next[KEY_BACK] = 1'b1;
            back_long_next         = 1'b0;
            change_next[KEY_BACK]  = poll.now_ms;
        end
        else if (!lvl[KEY_BACK] && exit_hit)
        begin
            if (!back_long_reg)
            begin
                back_long_next    = 1'b1;
                slot_v[SLOT_BACK] = 1'b1;
                slot_c[SLOT_BACK] = EV_EXIT;
            end
        end
        else if (lvl[KEY_BACK] && pressed_reg[KEY_BACK] && settled[KEY_BACK])
        begin
            pressed_next[KEY_BACK] = 1'b0;
            change_next[KEY_BACK]  = poll.now_ms;
            slot_v[SLOT_BACK]      = !back_long_reg;
            slot_c[SLOT_BACK]      = EV_BACK;
        end
    end

    // Pack the valid slots toward index 0, keeping their order
    always_comb
    begin
        ev_cnt = '0;
        for (int i = 0; i < MAX_EVENTS; i++)
        begin
            packed_codes[i] = EV_LEFT;
        end
        for (int i = 0; i < MAX_EVENTS; i++)
        begin
            if (slot_v[i])
            begin
                packed_codes[ev_cnt[EVIDX_W-1:0]] = slot_c[i];
                ev_cnt = ev_cnt + 1'b1;
            end
        end
        q_data.has_event = (ev_cnt != '0);
        q_data.last_idx  = (ev_cnt == '0) ? '0 : EVIDX_W'(ev_cnt - 1'b1);
        q_data.codes     = packed_codes;
    end

    // Hold registers and key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
            exit_hold_reg  <= EXIT_HOLD_RESET;
            pressed_reg    <= '0;
            side_long_reg  <= '0;
            back_long_reg  <= 1'b0;
            chord_reg      <= 1'b0;
            for (int k = 0; k < NUM_TIMERS; k++)
            begin
                change_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_DEBOUNCE:   debounce_reg   <= cfg.data;
                    REG_LONG_PRESS: long_press_reg <= cfg.data;
                    REG_EXIT_HOLD:  exit_hold_reg  <= cfg.data;
                    default:        ;
                endcase
            end
            if (accept)
            begin
                pressed_reg   <= pressed_next;
                side_long_reg <= side_long_next;
                back_long_reg <= back_long_next;
                chord_reg     <= chord_next;
                change_reg    <= change_next;
            end
        end
    end

endmodule

### sv/fkdc_evq.sv
// ----------------------------------------------------------------------------
// fkdc_evq
// Short queue of poll records between the front end and the event
// serializer.
// ----------------------------------------------------------------------------
module fkdc_evq #(
    parameter int DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  fkdc_pkg::poll_result_t push_data,
    output logic                   full,
    input  logic                   pop,
    output logic                   head_valid,
    output fkdc_pkg::poll_result_t head
);
    import fkdc_pkg::*;

    `include "four_key_debounce_long_press_chord_assert.svh"

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    poll_result_t   entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           wr_en;
    logic           rd_en;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = pop && head_valid;

    // Store the record
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `FKDC_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full, "push into full queue")
    `FKDC_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= CW'(DEPTH), "count out of range")
    `FKDC_ASSERT_NEXT(a_count_up, clk, rst_n, wr_en && !rd_en, count_reg == CW'($past(count_reg) + 1'b1), "count did not advance")

endmodule

### sv/fkdc_back.sv
// ----------------------------------------------------------------------------
// fkdc_back
// Event serializer: walks the events of the head poll record one beat at a
// time into an output register and drops the record after its last beat.
// ----------------------------------------------------------------------------
module fkdc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  fkdc_pkg::poll_result_t head,
    output logic                   pop,
    fkdc_event_if.source           evt
);
    import fkdc_pkg::*;

    `include "four_key_debounce_long_press_chord_assert.svh"

    logic               out_valid_reg;
    logic               has_event_reg;
    logic [3:0]         code_reg;
    logic               last_reg;
    logic [EVIDX_W-1:0] idx_reg;
    logic               load;
    logic               at_last;

    assign load    = head_valid && (!out_valid_reg || evt.ready);
    assign at_last = (idx_reg == head.last_idx);
    assign pop     = load && at_last;

    assign evt.valid        = out_valid_reg;
    assign evt.has_event    = has_event_reg;
    assign evt.event_code   = code_reg;
    assign evt.last_of_poll = last_reg;

    // Hold the output beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            has_event_reg <= head.has_event;
            code_reg      <= 4'(head.codes[idx_reg]);
            last_reg      <= at_last;
        end
    end

    // Advance through the record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= at_last ? '0 : idx_reg + 1'b1;
            end
            else if (evt.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `FKDC_ASSERT_IMPL(a_idx_in_record, clk, rst_n, idx_reg != '0, head_valid && (idx_reg <= head.last_idx), "index past record")
    `FKDC_ASSERT_IMPL(a_empty_is_last, clk, rst_n, out_valid_reg && !has_event_reg, last_reg, "empty poll not last")
    `FKDC_ASSERT_NEXT(a_idx_step, clk, rst_n, load && !at_last, idx_reg == EVIDX_W'($past(idx_reg) + 1'b1), "index did not step")

endmodule

### sv/four_key_debounce_long_press_chord.sv
// ----------------------------------------------------------------------------
// four_key_debounce_long_press_chord
// Four-key poller with debounce, long press, auto-repeat, left+right chord
// and exit on a long back press.
// ----------------------------------------------------------------------------
// One poll is accepted per cycle as long as the record queue has room; each
// poll yields one to four result beats (one empty beat when nothing
// happened), and the serializer puts out one beat per cycle while the
// receiver is ready, so a steady stream of polls is paced by its beats.
// A poll's first beat passes through a queue entry and the output register.
// Register writes take effect on the next poll.
// ----------------------------------------------------------------------------
module four_key_debounce_long_press_chord #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    fkdc_poll_if.sink     poll,
    fkdc_cfg_if.sink      cfg,
    fkdc_event_if.source  evt
);
    import fkdc_pkg::*;

    logic         q_full;
    logic         q_push;
    poll_result_t q_data;
    logic         q_pop;
    logic         q_head_valid;
    poll_result_t q_head;

    // Debounce and classify
    fkdc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .poll   (poll),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_data)
    );

    // Decouple the two sides
    fkdc_evq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_evq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // Serialize events
    fkdc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .evt        (evt)
    );

endmodule

### tb/tb_four_key_debounce_long_press_chord.sv
// ----------------------------------------------------------------------------
// tb_four_key_debounce_long_press_chord
// Self-checking bench for the four-key poller. Polls go in through the poll
// channel, and every event beat is checked against a local model of the
// debounce, long press, repeat, chord and exit logic. The bench runs
// directed key sequences, then random well-formed key activity under several
// register settings, with random gaps on both channels and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_four_key_debounce_long_press_chord;

    timeunit 1ns;
    timeprecision 1ps;

    import fkdc_pkg::*;

    localparam int                   LIMIT_CYCLES  = 600000;
    localparam int                   SETTLE_CYCLES = 8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 2'd3;

    typedef struct packed {
        logic       has_event;
        logic [3:0] code;
        logic       last;
    } beat_t;

    logic clk;
    logic rst_n;

    fkdc_poll_if  poll_bus ();
    fkdc_cfg_if   cfg_bus ();
    fkdc_event_if evt_bus ();

    four_key_debounce_long_press_chord u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .poll  (poll_bus),
        .cfg   (cfg_bus),
        .evt   (evt_bus)
    );

    // Model state and register copies
    logic              key_down    [NUM_TIMERS];
    logic              long_held   [NUM_KEYS];
    logic [TIME_W-1:0] last_change [NUM_TIMERS];
    logic              chord_on;
    logic [CFG_W-1:0]  db_ms;
    logic [CFG_W-1:0]  lp_ms;
    logic [CFG_W-1:0]  eh_ms;

    event_code_t poll_events [$];
    beat_t       expected_beats [$];

    int                error_count;
    int                tx_burst;
    int                rx_hold_cycles;
    int unsigned       cycle_count;
    logic [TIME_W-1:0] tick_ms;
    logic              pin_left;
    logic              pin_right;
    logic              pin_ok;
    logic              pin_back;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_four_key_debounce_long_press_chord NOT OK");
        $finish;
    end

    function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] now, input int k);
        return now - last_change[k];
    endfunction

    // Left or right key outside chord mode
    task automatic side_key_step(input int k, input logic [TIME_W-1:0] now, input logic lvl);
        if (!lvl && !key_down[k] && elapsed(now, k) > db_ms)
        begin
            key_down[k]    = 1'b1;
            long_held[k]   = 1'b0;
            last_change[k] = now;
        end
        else if (!lvl && elapsed(now, k) > lp_ms)
        begin
            long_held[k]   = 1'b1;
            last_change[k] = now;
            poll_events.push_back((k == KEY_LEFT) ? EV_LEFT_LONG : EV_RIGHT_LONG);
        end
        else if (lvl && key_down[k] && elapsed(now, k) > db_ms)
        begin
            key_down[k]    = 1'b0;
            last_change[k] = now;
            if (!long_held[k])
                poll_events.push_back((k == KEY_LEFT) ? EV_LEFT : EV_RIGHT);
        end
    endtask

    // Advance the model by one poll and queue the beats it should produce
    task automatic predict_events(input logic [TIME_W-1:0] now, input logic l, input logic r,
                                  input logic ok, input logic bk);
        beat_t b;
        poll_events.delete();

        // Chord entry and exit
        if (l && r)
        begin
            chord_on           = 1'b0;
            key_down[KEY_CHORD] = 1'b0;
        end
        else if (!l && !r)
        begin
            chord_on            = 1'b1;
            key_down[KEY_LEFT]  = 1'b0;
            key_down[KEY_RIGHT] = 1'b0;
        end

        if (chord_on)
        begin
            if (elapsed(now, KEY_CHORD) > db_ms)
            begin
                if (!l && !r && !key_down[KEY_CHORD])
                begin
                    key_down[KEY_CHORD]    = 1'b1;
                    last_change[KEY_CHORD] = now;
                end
                else if ((l != r) && key_down[KEY_CHORD])
                begin
                    key_down[KEY_CHORD]    = 1'b0;
                    last_change[KEY_CHORD] = now;
                    poll_events.push_back(l ? EV_UP : EV_DOWN);
                end
            end
        end
        else
        begin
            side_key_step(KEY_LEFT, now, l);
            side_key_step(KEY_RIGHT, now, r);
        end

        // Ok key
        if (!ok && !key_down[KEY_OK] && elapsed(now, KEY_OK) > db_ms)
        begin
            key_down[KEY_OK]    = 1'b1;
            last_change[KEY_OK] = now;
        end
        else if (ok && key_down[KEY_OK] && elapsed(now, KEY_OK) > db_ms)
        begin
            key_down[KEY_OK]    = 1'b0;
            last_change[KEY_OK] = now;
            poll_events.push_back(EV_OK);
        end

        // Back key, exit once per hold
        if (!bk && !key_down[KEY_BACK] && elapsed(now, KEY_BACK) > db_ms)
        begin
            key_down[KEY_BACK]    = 1'b1;
            long_held[KEY_BACK]   = 1'b0;
            last_change[KEY_BACK] = now;
        end
        else if (!bk && elapsed(now, KEY_BACK) > eh_ms)
        begin
            if (!long_held[KEY_BACK])
            begin
                long_held[KEY_BACK] = 1'b1;
                poll_events.push_back(EV_EXIT);
            end
        end
        else if (bk && key_down[KEY_BACK] && elapsed(now, KEY_BACK) > db_ms)
        begin
            key_down[KEY_BACK]    = 1'b0;
            last_change[KEY_BACK] = now;
            if (!long_held[KEY_BACK])
                poll_events.push_back(EV_BACK);
        end

        // Pack into beats; an empty poll still gives one beat
        if (poll_events.size() == 0)
        begin
            b = '{has_event: 1'b0, code: 4'd0, last: 1'b1};
            expected_beats.push_back(b);
        end
        else
        begin
            foreach (poll_events[i])
            begin
                b.has_event = 1'b1;
                b.code      = poll_events[i];
                b.last      = (i == poll_events.size() - 1);
                expected_beats.push_back(b);
            end
        end
    endtask

    // Sender gap: mostly none, some short, a few long, with back-to-back bursts
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_burst > 0)
        begin
            tx_burst--;
            return 0;
        end
        if (r < 4)
        begin
            tx_burst = $urandom_range(15, 50);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Offer one poll beat and wait until it is taken
    task automatic send_poll(input logic [TIME_W-1:0] now, input logic l, input logic r,
                             input logic ok, input logic bk);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            poll_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        poll_bus.valid       <= 1'b1;
        poll_bus.now_ms      <= now;
        poll_bus.left_level  <= l;
        poll_bus.right_level <= r;
        poll_bus.ok_level    <= ok;
        poll_bus.back_level  <= bk;
        do
            @(posedge clk);
        while (!poll_bus.ready);
        predict_events(now, l, r, ok, bk);
    endtask

    // Drop valid and wait until every expected beat has come back
    task automatic drain_results();
        @(negedge clk);
        poll_bus.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            REG_DEBOUNCE:   db_ms = val;
            REG_LONG_PRESS: lp_ms = val;
            REG_EXIT_HOLD:  eh_ms = val;
            default:        ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_W-1:0] db, input logic [CFG_W-1:0] lp,
                              input logic [CFG_W-1:0] eh);
        drain_results();
        write_reg(REG_DEBOUNCE, db);
        write_reg(REG_LONG_PRESS, lp);
        write_reg(REG_EXIT_HOLD, eh);
    endtask

    // Step the tick count, scaled to the current delays
    task automatic advance_clock();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            tick_ms = $urandom;
        else if (r < 47)
            tick_ms = tick_ms + $urandom_range(0, int'(db_ms) + 2);
        else if (r < 82)
            tick_ms = tick_ms + $urandom_range(0, int'(db_ms) + int'(lp_ms) + 2);
        else if (r < 96)
            tick_ms = tick_ms + $urandom_range(0, int'(eh_ms) + int'(eh_ms) / 4 + 2);
        else if (r < 98)
            tick_ms = tick_ms + $urandom;
        // else hold the same tick
    endtask

    // Keys mostly held across polls, some chord moves, some noise
    task automatic next_levels();
        int r;
        logic both;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            {pin_left, pin_right, pin_ok, pin_back} = 4'($urandom_range(0, 15));
        end
        else if (r < 25)
        begin
            both      = 1'($urandom_range(0, 1));
            pin_left  = both;
            pin_right = both;
        end
        else
        begin
            if ($urandom_range(0, 9) < 3) pin_left  = ~pin_left;
            if ($urandom_range(0, 9) < 3) pin_right = ~pin_right;
            if ($urandom_range(0, 9) < 3) pin_ok    = ~pin_ok;
            if ($urandom_range(0, 9) < 3) pin_back  = ~pin_back;
        end
    endtask

    task automatic run_random_polls(input int count);
        repeat (count)
        begin
            advance_clock();
            next_levels();
            send_poll(tick_ms, pin_left, pin_right, pin_ok, pin_back);
        end
    endtask

    // Short presses of each key, then three releases in one poll
    task automatic test_basic_keys();
        send_poll(32'd10,  1'b1, 1'b1, 1'b1, 1'b1);
        send_poll(32'd100, 1'b0, 1'b1, 1'b1, 1'b1);
        send_poll(32'd200, 1'b1, 1'b1, 1'b1, 1'b1);
        send_poll(32'd300, 1'b1, 1'b0, 1'b0, 1'b0);
        send_poll(32'd400, 1'b1, 1'b1, 1'b1, 1'b1);
    endtask

    // Left held past the long delay repeats, release gives nothing
    task automatic test_long_repeat();
        send_poll(32'd500,  1'b0, 1'b1, 1'b1, 1'b1);
        send_poll(32'd1100, 1'b0, 1'b1, 1'b1, 1'b1);
        send_poll(32'd1700, 1'b0, 1'b1, 1'b1, 1'b1);
        send_poll(32'd1800, 1'b1, 1'b1, 1'b1, 1'b1);
    endtask

    // Both held, then release one key for down and for up
    task automatic test_chord();
        send_poll(32'd2000, 1'b0, 1'b0, 1'b1, 1'b1);
        send_poll(32'd2100, 1'b1, 1'b0, 1'b1, 1'b1);
        send_poll(32'd2200, 1'b1, 1'b1, 1'b1, 1'b1);
        send_poll(32'd2300, 1'b0, 1'b0, 1'b1, 1'b1);
        send_poll(32'd2400, 1'b0, 1'b1, 1'b1, 1'b1);
        send_poll(32'd2500, 1'b1, 1'b1, 1'b1, 1'b1);
    endtask

    // Back held past the exit delay: one exit per hold, no short on release
    task automatic test_back_exit();
        send_poll(32'd2600, 1'b1, 1'b1, 1'b1, 1'b0);
        send_poll(32'd8000, 1'b1, 1'b1, 1'b1, 1'b0);
        send_poll(32'd9000, 1'b1, 1'b1, 1'b1, 1'b0);
        send_poll(32'd9100, 1'b1, 1'b1, 1'b1, 1'b1);
    endtask

    // Long delay below debounce: left long, right, ok and back in one poll
    task automatic test_four_events();
        set_config(16'd100, 16'd10, 16'hFFFF);
        write_reg(REG_UNUSED, 16'hA5A5);
        send_poll(32'd10000, 1'b1, 1'b0, 1'b0, 1'b0);
        send_poll(32'd10050, 1'b0, 1'b1, 1'b0, 1'b0);
        send_poll(32'd10110, 1'b0, 1'b1, 1'b1, 1'b1);
        send_poll(32'd10300, 1'b1, 1'b1, 1'b1, 1'b1);
    endtask

    // Press before the tick count wraps, release after
    task automatic test_time_wrap();
        send_poll(32'hFFFF_FF00, 1'b0, 1'b1, 1'b1, 1'b1);
        send_poll(32'h0000_0080, 1'b1, 1'b1, 1'b1, 1'b1);
        tick_ms = 32'h0000_0080;
    endtask

    // Random key activity under minimum, maximum and mid-range delays
    task automatic test_random_settings();
        set_config(16'd0, 16'd0, 16'd0);
        write_reg(REG_UNUSED, 16'h5A5A);
        run_random_polls(100);
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random_polls(100);
        set_config(16'($urandom_range(0, 40)), 16'($urandom_range(0, 300)),
                   16'($urandom_range(0, 1500)));
        run_random_polls(105);
        set_config(16'($urandom_range(0, 200)), 16'($urandom_range(0, 2000)),
                   16'($urandom_range(0, 8000)));
        run_random_polls(110);
    endtask

    // Receiver holds off while polls keep coming back to back
    task automatic test_backpressure();
        drain_results();
        rx_hold_cycles = 300;
        tx_burst       = 20;
        run_random_polls(20);
        drain_results();
    endtask

    // Receiver ready: random stalls, steady stretches, and requested hold-off
    initial
    begin
        int stall_left;
        int run_left;
        int r;
        stall_left    = 0;
        run_left      = 0;
        evt_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                evt_bus.ready <= 1'b0;
                rx_hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                evt_bus.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                evt_bus.ready <= 1'b1;
                if (run_left > 0)
                    run_left--;
                else
                begin
                    r        = $urandom_range(0, 99);
                    run_left = (r < 10) ? $urandom_range(40, 150) : $urandom_range(0, 8);
                    r        = $urandom_range(0, 99);
                    if (r < 55)
                        stall_left = 0;
                    else if (r < 90)
                        stall_left = $urandom_range(1, 3);
                    else if (r < 97)
                        stall_left = $urandom_range(4, 12);
                    else
                        stall_left = $urandom_range(20, 60);
                end
            end
        end
    end

    // Check each event beat against the oldest expectation
    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && evt_bus.valid && evt_bus.ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("event beat with nothing expected: has_event %0d event_code %0d last %0d",
                       evt_bus.has_event, evt_bus.event_code, evt_bus.last_of_poll);
                error_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (evt_bus.has_event !== want.has_event)
                begin
                    $error("has_event: expected %0d, actual %0d", want.has_event,
                           evt_bus.has_event);
                    error_count++;
                end
                if (evt_bus.event_code !== want.code)
                begin
                    $error("event_code: expected %0d, actual %0d", want.code,
                           evt_bus.event_code);
                    error_count++;
                end
                if (evt_bus.last_of_poll !== want.last)
                begin
                    $error("last_of_poll: expected %0d, actual %0d", want.last,
                           evt_bus.last_of_poll);
                    error_count++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        error_count    = 0;
        tx_burst       = 0;
        rx_hold_cycles = 0;
        tick_ms        = '0;
        pin_left       = 1'b1;
        pin_right      = 1'b1;
        pin_ok         = 1'b1;
        pin_back       = 1'b1;
        chord_on       = 1'b0;
        db_ms          = DEBOUNCE_RESET;
        lp_ms          = LONG_PRESS_RESET;
        eh_ms          = EXIT_HOLD_RESET;
        for (int k = 0; k < NUM_TIMERS; k++)
        begin
            key_down[k]    = 1'b0;
            last_change[k] = '0;
        end
        for (int k = 0; k < NUM_KEYS; k++)
            long_held[k] = 1'b0;

        rst_n                = 1'b0;
        poll_bus.valid       = 1'b0;
        poll_bus.now_ms      = '0;
        poll_bus.left_level  = 1'b1;
        poll_bus.right_level = 1'b1;
        poll_bus.ok_level    = 1'b1;
        poll_bus.back_level  = 1'b1;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = REG_DEBOUNCE;
        cfg_bus.data         = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_keys();
        test_long_repeat();
        test_chord();
        test_back_exit();
        test_four_events();
        test_time_wrap();
        test_random_settings();
        test_backpressure();

        drain_results();
        if (error_count == 0)
            $display("tb_four_key_debounce_long_press_chord OK");
        else
            $display("tb_four_key_debounce_long_press_chord NOT OK");
        $finish;
    end

endmodule
